// ----- sv/vnmr_pkg.sv -----
package vnmr_pkg;

   // payload widths
   localparam int KIND_W   = 2;
   localparam int OFFSET_W = 12;
   localparam int DATA_W   = 32;
   localparam int BYTES_W  = 3;
   localparam int MAC_W    = 48;
   localparam int QLEN_W   = 16;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   // parameter defaults
   localparam int QUEUE_SIZE_DEF = 256;
   localparam int NUM_QUEUES_DEF = 2;

   // identification values
   localparam logic [DATA_W-1:0] MAGIC_VALUE   = 32'h7472_6976;
   localparam logic [DATA_W-1:0] VERSION_VALUE = 32'd2;
   localparam logic [DATA_W-1:0] DEVICE_ID     = 32'd1;
   localparam logic [DATA_W-1:0] VENDOR_VALUE  = 32'h554D_4551;
   localparam logic [63:0]       FEATURE_RESET = 64'h0000_0001_0000_0020;

   // register offsets
   localparam logic [OFFSET_W-1:0] OFF_MAGIC       = 12'h000;
   localparam logic [OFFSET_W-1:0] OFF_VERSION     = 12'h004;
   localparam logic [OFFSET_W-1:0] OFF_DEVICE_ID   = 12'h008;
   localparam logic [OFFSET_W-1:0] OFF_VENDOR_ID   = 12'h00C;
   localparam logic [OFFSET_W-1:0] OFF_DEV_FEAT    = 12'h010;
   localparam logic [OFFSET_W-1:0] OFF_DEV_FEAT_S  = 12'h014;
   localparam logic [OFFSET_W-1:0] OFF_DRV_FEAT    = 12'h020;
   localparam logic [OFFSET_W-1:0] OFF_DRV_FEAT_S  = 12'h024;
   localparam logic [OFFSET_W-1:0] OFF_QUEUE_SEL   = 12'h030;
   localparam logic [OFFSET_W-1:0] OFF_QUEUE_MAX   = 12'h034;
   localparam logic [OFFSET_W-1:0] OFF_QUEUE_NUM   = 12'h038;
   localparam logic [OFFSET_W-1:0] OFF_QUEUE_READY = 12'h044;
   localparam logic [OFFSET_W-1:0] OFF_NOTIFY      = 12'h050;
   localparam logic [OFFSET_W-1:0] OFF_IRQ_STATUS  = 12'h060;
   localparam logic [OFFSET_W-1:0] OFF_IRQ_ACK     = 12'h064;
   localparam logic [OFFSET_W-1:0] OFF_STATUS      = 12'h070;
   localparam logic [OFFSET_W-1:0] OFF_DESC_LO     = 12'h080;
   localparam logic [OFFSET_W-1:0] OFF_DESC_HI     = 12'h084;
   localparam logic [OFFSET_W-1:0] OFF_AVAIL_LO    = 12'h090;
   localparam logic [OFFSET_W-1:0] OFF_AVAIL_HI    = 12'h094;
   localparam logic [OFFSET_W-1:0] OFF_USED_LO     = 12'h0A0;
   localparam logic [OFFSET_W-1:0] OFF_USED_HI     = 12'h0A4;
   localparam logic [OFFSET_W-1:0] OFF_CONFIG      = 12'h100;

   // station address window
   localparam int MAC_BYTES = 6;
   localparam int MAX_READ_BYTES = 4;

   // csr register index
   localparam logic CSR_IDX_MAC = 1'b0;

   typedef enum logic [KIND_W-1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_EVENT = 2'd2
   } kind_type;

endpackage

// ----- sv/vnmr_if.sv -----
// request channel: one bus access or completion event per beat
interface vnmr_req_if;
   logic                                valid;
   logic                                ready;
   logic [vnmr_pkg::KIND_W-1:0]         kind;
   logic [vnmr_pkg::OFFSET_W-1:0]       reg_offset;
   logic [vnmr_pkg::DATA_W-1:0]         write_data;
   logic [vnmr_pkg::BYTES_W-1:0]        access_bytes;

   modport source (output valid, kind, reg_offset, write_data, access_bytes, input ready);
   modport sink (input valid, kind, reg_offset, write_data, access_bytes, output ready);
endinterface

// response channel: one result per request beat
interface vnmr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [vnmr_pkg::DATA_W-1:0]   read_data;
   logic                          notify_tx;
   logic                          irq_raise;
   logic                          ring_reset;

   modport source (output valid, read_data, notify_tx, irq_raise, ring_reset, input ready);
   modport sink (input valid, read_data, notify_tx, irq_raise, ring_reset, output ready);
endinterface

// ----- sv/virtio_net_mmio_registers_unit.sv -----
// virtio-mmio version 2 register front end for a network device.
// req carries one beat per bus read, bus write or queue completion event;
// rsp returns exactly one beat for each, in order: read data (zero for
// writes and events) plus the notify, interrupt-raise and ring-reset pulses.
// the csr_ apb port holds the 48-bit station address at byte address 0;
// pready is always high and a write lands on the access cycle.
// the access is decoded and the register file updated at the accepting edge,
// and the result is held in the rsp output register, on rsp the next cycle.
// throughput is one beat per cycle while rsp is taken, set by that single register stage.
// req.ready stays high while the output register is empty or being taken,
// so a stalled receiver holds one result and stalls req behind it.
// synchronous reset empties the output register, restores the feature word
// to its default and clears selects, queue setup, status and the address.
module virtio_net_mmio_registers_unit #(
   parameter int QUEUE_SIZE = vnmr_pkg::QUEUE_SIZE_DEF,
   parameter int NUM_QUEUES = vnmr_pkg::NUM_QUEUES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   vnmr_req_if.sink                          req,
   vnmr_rsp_if.source                        rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [vnmr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [vnmr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [vnmr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam logic [vnmr_pkg::QLEN_W-1:0] QSIZE = vnmr_pkg::QLEN_W'(QUEUE_SIZE);

   // register file
   logic [vnmr_pkg::MAC_W-1:0]  mac_ff, mac_in;
   logic [63:0]                 feature_ff, feature_in;
   logic [31:0]                 dev_fsel_ff, dev_fsel_in;
   logic [31:0]                 drv_fsel_ff, drv_fsel_in;
   logic [31:0]                 queue_sel_ff, queue_sel_in;
   logic [31:0]                 irq_status_ff, irq_status_in;
   logic [31:0]                 dev_status_ff, dev_status_in;
   logic [vnmr_pkg::QLEN_W-1:0] queue_len_ff [NUM_QUEUES];
   logic [vnmr_pkg::QLEN_W-1:0] queue_len_in [NUM_QUEUES];
   logic [NUM_QUEUES-1:0]       queue_ready_ff, queue_ready_in;
   logic [1:0][31:0]            desc_addr_ff  [NUM_QUEUES];
   logic [1:0][31:0]            desc_addr_in  [NUM_QUEUES];
   logic [1:0][31:0]            avail_addr_ff [NUM_QUEUES];
   logic [1:0][31:0]            avail_addr_in [NUM_QUEUES];
   logic [1:0][31:0]            used_addr_ff  [NUM_QUEUES];
   logic [1:0][31:0]            used_addr_in  [NUM_QUEUES];

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [31:0]                 rsp_data_ff, rsp_data_in;
   logic                        rsp_notify_ff, rsp_notify_in;
   logic                        rsp_irq_ff, rsp_irq_in;
   logic                        rsp_rreset_ff, rsp_rreset_in;

   logic                        accept;
   logic                        qv;
   logic [QW-1:0]               qidx;
   logic [31:0]                 read_value;
   logic [31:0]                 mac_value;
   logic                        csr_write;

   // handshake
   assign req.ready  = !rsp_valid_ff || rsp.ready;
   assign accept     = req.valid && req.ready;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.read_data  = rsp_data_ff;
   assign rsp.notify_tx  = rsp_notify_ff;
   assign rsp.irq_raise  = rsp_irq_ff;
   assign rsp.ring_reset = rsp_rreset_ff;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[3] == vnmr_pkg::CSR_IDX_MAC);
   assign csr_prdata = (csr_paddr[3] == vnmr_pkg::CSR_IDX_MAC)
                       ? {{(vnmr_pkg::CSR_DATA_W - vnmr_pkg::MAC_W){1'b0}}, mac_ff}
                       : '0;
   assign mac_in = csr_write ? csr_pwdata[vnmr_pkg::MAC_W-1:0] : mac_ff;

   // selected queue
   assign qv   = queue_sel_ff < 32'(NUM_QUEUES);
   assign qidx = queue_sel_ff[QW-1:0];

   // station address bytes, little endian, clipped to the window
   always_comb begin
      logic [2:0] start;
      logic [2:0] nbytes;
      logic [3:0] pos;
      start  = req.reg_offset[2:0];
      nbytes = (req.access_bytes > 3'(vnmr_pkg::MAX_READ_BYTES))
               ? 3'(vnmr_pkg::MAX_READ_BYTES) : req.access_bytes;
      mac_value = '0;
      for (int i = 0; i < vnmr_pkg::MAX_READ_BYTES; i++) begin
         pos = {1'b0, start} + 4'(i);
         if ((3'(i) < nbytes) && (pos < 4'(vnmr_pkg::MAC_BYTES))) begin
            mac_value[i*8 +: 8] = mac_ff[{pos[2:0], 3'b000} +: 8];
         end
      end
   end

   // read decode
   always_comb begin
      read_value = '0;
      if ((req.reg_offset[11:3] == vnmr_pkg::OFF_CONFIG[11:3])
          && (req.reg_offset[2:0] < 3'(vnmr_pkg::MAC_BYTES))) begin
         read_value = mac_value;
      end else begin
         case (req.reg_offset)
            vnmr_pkg::OFF_MAGIC:       read_value = vnmr_pkg::MAGIC_VALUE;
            vnmr_pkg::OFF_VERSION:     read_value = vnmr_pkg::VERSION_VALUE;
            vnmr_pkg::OFF_DEVICE_ID:   read_value = vnmr_pkg::DEVICE_ID;
            vnmr_pkg::OFF_VENDOR_ID:   read_value = vnmr_pkg::VENDOR_VALUE;
            vnmr_pkg::OFF_DEV_FEAT: begin
               if (dev_fsel_ff == 32'd0) begin
                  read_value = feature_ff[31:0];
               end else if (dev_fsel_ff == 32'd1) begin
                  read_value = feature_ff[63:32];
               end
            end
            vnmr_pkg::OFF_QUEUE_MAX:   read_value = 32'(QUEUE_SIZE);
            vnmr_pkg::OFF_QUEUE_READY: read_value = {31'd0, qv && queue_ready_ff[qidx]};
            vnmr_pkg::OFF_IRQ_STATUS:  read_value = irq_status_ff;
            vnmr_pkg::OFF_STATUS:      read_value = dev_status_ff;
            default:                   read_value = '0;
         endcase
      end
   end

   // access execution and next state
   always_comb begin
      feature_in     = feature_ff;
      dev_fsel_in    = dev_fsel_ff;
      drv_fsel_in    = drv_fsel_ff;
      queue_sel_in   = queue_sel_ff;
      irq_status_in  = irq_status_ff;
      dev_status_in  = dev_status_ff;
      queue_len_in   = queue_len_ff;
      queue_ready_in = queue_ready_ff;
      desc_addr_in   = desc_addr_ff;
      avail_addr_in  = avail_addr_ff;
      used_addr_in   = used_addr_ff;
      rsp_data_in    = '0;
      rsp_notify_in  = 1'b0;
      rsp_irq_in     = 1'b0;
      rsp_rreset_in  = 1'b0;
      if (accept) begin
         case (vnmr_pkg::kind_type'(req.kind))
            vnmr_pkg::KIND_READ: begin
               rsp_data_in = read_value;
            end
            vnmr_pkg::KIND_WRITE: begin
               case (req.reg_offset)
                  vnmr_pkg::OFF_DEV_FEAT_S: dev_fsel_in = req.write_data;
                  vnmr_pkg::OFF_DRV_FEAT_S: drv_fsel_in = req.write_data;
                  vnmr_pkg::OFF_DRV_FEAT: begin
                     if (drv_fsel_ff == 32'd0) begin
                        feature_in[31:0] = req.write_data;
                     end else if (drv_fsel_ff == 32'd1) begin
                        feature_in[63:32] = req.write_data;
                     end
                  end
                  vnmr_pkg::OFF_QUEUE_SEL: queue_sel_in = req.write_data;
                  vnmr_pkg::OFF_QUEUE_NUM: begin
                     if (qv) begin
                        queue_len_in[qidx] = (req.write_data < 32'(QUEUE_SIZE))
                                             ? req.write_data[vnmr_pkg::QLEN_W-1:0] : QSIZE;
                     end
                  end
                  vnmr_pkg::OFF_QUEUE_READY: begin
                     if (qv) begin
                        queue_ready_in[qidx] = (req.write_data != 32'd0);
                     end
                  end
                  vnmr_pkg::OFF_NOTIFY: rsp_notify_in = (req.write_data == 32'd1);
                  vnmr_pkg::OFF_IRQ_ACK: irq_status_in = irq_status_ff & ~req.write_data;
                  vnmr_pkg::OFF_STATUS: begin
                     dev_status_in = req.write_data;
                     // status of zero: device reset of all queues
                     if (req.write_data == 32'd0) begin
                        for (int q = 0; q < NUM_QUEUES; q++) begin
                           queue_len_in[q]  = '0;
                           desc_addr_in[q]  = '0;
                           avail_addr_in[q] = '0;
                           used_addr_in[q]  = '0;
                        end
                        queue_ready_in = '0;
                        irq_status_in  = '0;
                        rsp_rreset_in  = 1'b1;
                     end
                  end
                  vnmr_pkg::OFF_DESC_LO:  if (qv) desc_addr_in[qidx][0]  = req.write_data;
                  vnmr_pkg::OFF_DESC_HI:  if (qv) desc_addr_in[qidx][1]  = req.write_data;
                  vnmr_pkg::OFF_AVAIL_LO: if (qv) avail_addr_in[qidx][0] = req.write_data;
                  vnmr_pkg::OFF_AVAIL_HI: if (qv) avail_addr_in[qidx][1] = req.write_data;
                  vnmr_pkg::OFF_USED_LO:  if (qv) used_addr_in[qidx][0]  = req.write_data;
                  vnmr_pkg::OFF_USED_HI:  if (qv) used_addr_in[qidx][1]  = req.write_data;
                  default: ;
               endcase
            end
            vnmr_pkg::KIND_EVENT: begin
               irq_status_in = irq_status_ff | 32'd1;
               rsp_irq_in    = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // output register control
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mac_ff         <= '0;
         feature_ff     <= vnmr_pkg::FEATURE_RESET;
         dev_fsel_ff    <= '0;
         drv_fsel_ff    <= '0;
         queue_sel_ff   <= '0;
         irq_status_ff  <= '0;
         dev_status_ff  <= '0;
         queue_ready_ff <= '0;
         for (int q = 0; q < NUM_QUEUES; q++) begin
            queue_len_ff[q]  <= '0;
            desc_addr_ff[q]  <= '0;
            avail_addr_ff[q] <= '0;
            used_addr_ff[q]  <= '0;
         end
         rsp_valid_ff   <= 1'b0;
      end else begin
         mac_ff         <= mac_in;
         feature_ff     <= feature_in;
         dev_fsel_ff    <= dev_fsel_in;
         drv_fsel_ff    <= drv_fsel_in;
         queue_sel_ff   <= queue_sel_in;
         irq_status_ff  <= irq_status_in;
         dev_status_ff  <= dev_status_in;
         queue_ready_ff <= queue_ready_in;
         queue_len_ff   <= queue_len_in;
         desc_addr_ff   <= desc_addr_in;
         avail_addr_ff  <= avail_addr_in;
         used_addr_ff   <= used_addr_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload, loaded on each accepted beat
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_notify_ff <= rsp_notify_in;
         rsp_irq_ff    <= rsp_irq_in;
         rsp_rreset_ff <= rsp_rreset_in;
      end
   end

   // checks
   a_event_sets_irq: assert property (@(posedge clock) disable iff (reset)
      accept && (req.kind == vnmr_pkg::KIND_EVENT) |=> irq_status_ff[0] && rsp.irq_raise)
      else $error("completion event did not set interrupt status");

   a_ring_reset_clears: assert property (@(posedge clock) disable iff (reset)
      accept && (req.kind == vnmr_pkg::KIND_WRITE)
      && (req.reg_offset == vnmr_pkg::OFF_STATUS) && (req.write_data == 32'd0)
      |=> (queue_ready_ff == '0) && (irq_status_ff == '0) && rsp.ring_reset)
      else $error("status write of zero did not reset the queues");

   a_pulse_only_on_write: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.notify_tx || rsp.ring_reset) |-> (rsp.read_data == '0) && !rsp.irq_raise)
      else $error("write pulse carried read data or interrupt");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("request taken while result held");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

   localparam int QSIZE       = vnmr_pkg::QUEUE_SIZE_DEF;
   localparam int NQ          = vnmr_pkg::NUM_QUEUES_DEF;
   localparam int LATENCY     = 1;
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_SHOWN   = 10;
   localparam int NUM_DECODED = 28;

   typedef struct packed {
      logic [vnmr_pkg::DATA_W-1:0] read_data;
      logic                        notify_tx;
      logic                        irq_raise;
      logic                        ring_reset;
   } mmio_result_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [vnmr_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [vnmr_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [vnmr_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   vnmr_req_if req();
   vnmr_rsp_if rsp();

   virtio_net_mmio_registers_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 10 ns clock
   always #5 clock = ~clock;

   // register file mirror
   logic [63:0]                 feature_word;
   logic [vnmr_pkg::DATA_W-1:0] dev_feat_sel;
   logic [vnmr_pkg::DATA_W-1:0] drv_feat_sel;
   logic [vnmr_pkg::DATA_W-1:0] queue_sel;
   logic [vnmr_pkg::DATA_W-1:0] irq_status;
   logic [vnmr_pkg::DATA_W-1:0] dev_status;
   logic [vnmr_pkg::QLEN_W-1:0] queue_len [NQ];
   logic                        queue_rdy [NQ];
   logic [63:0]                 desc_ring [NQ];
   logic [63:0]                 avail_ring [NQ];
   logic [63:0]                 used_ring [NQ];
   logic [vnmr_pkg::MAC_W-1:0]  station_mac;

   mmio_result_type mmio_results_due [$];
   int              mismatch_count;
   int              idle_count;
   int              rsp_hold_cycles;
   bit              idle_on;

   function automatic void clear_queue_setup();
      int i;
      for (i = 0; i < NQ; i++) begin
         queue_len[i]  = '0;
         queue_rdy[i]  = 1'b0;
         desc_ring[i]  = '0;
         avail_ring[i] = '0;
         used_ring[i]  = '0;
      end
   endfunction

   function automatic void reset_register_mirror();
      feature_word = vnmr_pkg::FEATURE_RESET;
      dev_feat_sel = '0;
      drv_feat_sel = '0;
      queue_sel    = '0;
      irq_status   = '0;
      dev_status   = '0;
      station_mac  = '0;
      clear_queue_setup();
   endfunction

   // decode one access against the mirror and return the beat it yields
   function automatic mmio_result_type mmio_access_result(
         input logic [vnmr_pkg::KIND_W-1:0]   kind,
         input logic [vnmr_pkg::OFFSET_W-1:0] off,
         input logic [vnmr_pkg::DATA_W-1:0]   data,
         input logic [vnmr_pkg::BYTES_W-1:0]  nbytes);
      mmio_result_type beat;
      logic            sel_ok;
      int              q;
      int              start;
      int              n;
      int              i;
      beat   = '0;
      sel_ok = (queue_sel < NQ);
      q      = sel_ok ? int'(queue_sel) : 0;
      case (kind)
         vnmr_pkg::KIND_READ: begin
            if (off >= vnmr_pkg::OFF_CONFIG
                && off < vnmr_pkg::OFF_CONFIG + vnmr_pkg::MAC_BYTES) begin
               // station address bytes, clipped to four and to the last byte
               start = int'(off - vnmr_pkg::OFF_CONFIG);
               n = (nbytes > vnmr_pkg::MAX_READ_BYTES) ? vnmr_pkg::MAX_READ_BYTES
                                                       : int'(nbytes);
               for (i = 0; i < n && start + i < vnmr_pkg::MAC_BYTES; i++)
                  beat.read_data[8*i +: 8] = station_mac[8*(start+i) +: 8];
            end else begin
               case (off)
                  vnmr_pkg::OFF_MAGIC:     beat.read_data = vnmr_pkg::MAGIC_VALUE;
                  vnmr_pkg::OFF_VERSION:   beat.read_data = vnmr_pkg::VERSION_VALUE;
                  vnmr_pkg::OFF_DEVICE_ID: beat.read_data = vnmr_pkg::DEVICE_ID;
                  vnmr_pkg::OFF_VENDOR_ID: beat.read_data = vnmr_pkg::VENDOR_VALUE;
                  vnmr_pkg::OFF_DEV_FEAT: begin
                     if (dev_feat_sel == 0)
                        beat.read_data = feature_word[31:0];
                     else if (dev_feat_sel == 1)
                        beat.read_data = feature_word[63:32];
                  end
                  vnmr_pkg::OFF_QUEUE_MAX:
                     beat.read_data = vnmr_pkg::DATA_W'(QSIZE);
                  vnmr_pkg::OFF_QUEUE_READY:
                     beat.read_data = vnmr_pkg::DATA_W'(sel_ok && queue_rdy[q]);
                  vnmr_pkg::OFF_IRQ_STATUS: beat.read_data = irq_status;
                  vnmr_pkg::OFF_STATUS:     beat.read_data = dev_status;
                  default:                  beat.read_data = '0;
               endcase
            end
         end
         vnmr_pkg::KIND_WRITE: begin
            case (off)
               vnmr_pkg::OFF_DEV_FEAT_S: dev_feat_sel = data;
               vnmr_pkg::OFF_DRV_FEAT_S: drv_feat_sel = data;
               vnmr_pkg::OFF_DRV_FEAT: begin
                  if (drv_feat_sel == 0)
                     feature_word[31:0] = data;
                  else if (drv_feat_sel == 1)
                     feature_word[63:32] = data;
               end
               vnmr_pkg::OFF_QUEUE_SEL: queue_sel = data;
               vnmr_pkg::OFF_QUEUE_NUM: begin
                  if (sel_ok)
                     queue_len[q] = (data < QSIZE) ? data[vnmr_pkg::QLEN_W-1:0]
                                                   : vnmr_pkg::QLEN_W'(QSIZE);
               end
               vnmr_pkg::OFF_QUEUE_READY: if (sel_ok) queue_rdy[q] = (data != 0);
               vnmr_pkg::OFF_NOTIFY:      beat.notify_tx = (data == 1);
               vnmr_pkg::OFF_IRQ_ACK:     irq_status = irq_status & ~data;
               vnmr_pkg::OFF_STATUS: begin
                  dev_status = data;
                  if (data == 0) begin
                     clear_queue_setup();
                     irq_status      = '0;
                     beat.ring_reset = 1'b1;
                  end
               end
               vnmr_pkg::OFF_DESC_LO:  if (sel_ok) desc_ring[q][31:0]   = data;
               vnmr_pkg::OFF_DESC_HI:  if (sel_ok) desc_ring[q][63:32]  = data;
               vnmr_pkg::OFF_AVAIL_LO: if (sel_ok) avail_ring[q][31:0]  = data;
               vnmr_pkg::OFF_AVAIL_HI: if (sel_ok) avail_ring[q][63:32] = data;
               vnmr_pkg::OFF_USED_LO:  if (sel_ok) used_ring[q][31:0]   = data;
               vnmr_pkg::OFF_USED_HI:  if (sel_ok) used_ring[q][63:32]  = data;
               default: ;
            endcase
         end
         vnmr_pkg::KIND_EVENT: begin
            irq_status[0]  = 1'b1;
            beat.irq_raise = 1'b1;
         end
         default: ;
      endcase
      return beat;
   endfunction

   task automatic report_mismatch(input string what, input mmio_result_type want,
                                  input mmio_result_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN)
         $display({"%0t %s: expected data=%h notify=%b irq=%b rst=%b, ",
                   "got data=%h notify=%b irq=%b rst=%b"},
                  $realtime, what, want.read_data, want.notify_tx, want.irq_raise,
                  want.ring_reset, got.read_data, got.notify_tx, got.irq_raise,
                  got.ring_reset);
   endtask

   // check each rsp beat, then record the prediction for each req beat
   always @(posedge clock) begin : result_check
      mmio_result_type got;
      mmio_result_type want;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            got = {rsp.read_data, rsp.notify_tx, rsp.irq_raise, rsp.ring_reset};
            if (mmio_results_due.size() == 0) begin
               report_mismatch("unexpected rsp beat", '0, got);
            end else begin
               want = mmio_results_due.pop_front();
               if (got.read_data !== want.read_data || got.notify_tx !== want.notify_tx ||
                   got.irq_raise !== want.irq_raise || got.ring_reset !== want.ring_reset)
                  report_mismatch("rsp beat mismatch", want, got);
            end
         end
         if (req.valid && req.ready)
            mmio_results_due.insert(mmio_results_due.size(),
                                    mmio_access_result(req.kind, req.reg_offset,
                                                       req.write_data, req.access_bytes));
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_count <= 0;
      end else if (idle_count >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles = rsp_hold_cycles - 1;
            rsp.ready <= 1'b0;
         end else if (idle_on) begin
            rsp.ready <= ($urandom_range(0, 99) >= 24);
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // offer one req beat and wait until it is taken
   task automatic send_access(input logic [vnmr_pkg::KIND_W-1:0]   kind,
                              input logic [vnmr_pkg::OFFSET_W-1:0] off,
                              input logic [vnmr_pkg::DATA_W-1:0]   data,
                              input logic [vnmr_pkg::BYTES_W-1:0]  nbytes);
      if (idle_on && $urandom_range(0, 99) < 24) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 24);
      end
      req.valid        <= 1'b1;
      req.kind         <= kind;
      req.reg_offset   <= off;
      req.write_data   <= data;
      req.access_bytes <= nbytes;
      do @(posedge clock); while (!req.ready);
   endtask

   // let every outstanding result come back
   task automatic drain();
      req.valid <= 1'b0;
      do @(posedge clock); while (mmio_results_due.size() != 0);
      repeat (LATENCY + 1) @(posedge clock);
   endtask

   task automatic program_station_address(input logic [vnmr_pkg::CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= vnmr_pkg::CSR_ADDR_W'(8 * int'(vnmr_pkg::CSR_IDX_MAC));
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      station_mac = value[vnmr_pkg::MAC_W-1:0];
   endtask

   function automatic logic [vnmr_pkg::OFFSET_W-1:0] decoded_offset(input int idx);
      case (idx)
         0:  return vnmr_pkg::OFF_MAGIC;
         1:  return vnmr_pkg::OFF_VERSION;
         2:  return vnmr_pkg::OFF_DEVICE_ID;
         3:  return vnmr_pkg::OFF_VENDOR_ID;
         4:  return vnmr_pkg::OFF_DEV_FEAT;
         5:  return vnmr_pkg::OFF_DEV_FEAT_S;
         6:  return vnmr_pkg::OFF_DRV_FEAT;
         7:  return vnmr_pkg::OFF_DRV_FEAT_S;
         8:  return vnmr_pkg::OFF_QUEUE_SEL;
         9:  return vnmr_pkg::OFF_QUEUE_MAX;
         10: return vnmr_pkg::OFF_QUEUE_NUM;
         11: return vnmr_pkg::OFF_QUEUE_READY;
         12: return vnmr_pkg::OFF_NOTIFY;
         13: return vnmr_pkg::OFF_IRQ_STATUS;
         14: return vnmr_pkg::OFF_IRQ_ACK;
         15: return vnmr_pkg::OFF_STATUS;
         16: return vnmr_pkg::OFF_DESC_LO;
         17: return vnmr_pkg::OFF_DESC_HI;
         18: return vnmr_pkg::OFF_AVAIL_LO;
         19: return vnmr_pkg::OFF_AVAIL_HI;
         20: return vnmr_pkg::OFF_USED_LO;
         21: return vnmr_pkg::OFF_USED_HI;
         default: return vnmr_pkg::OFF_CONFIG + vnmr_pkg::OFFSET_W'(idx - 22);
      endcase
   endfunction

   // mostly driver-like accesses to decoded registers, the rest noise
   task automatic send_random_access();
      logic [vnmr_pkg::KIND_W-1:0]   kind;
      logic [vnmr_pkg::OFFSET_W-1:0] off;
      logic [vnmr_pkg::DATA_W-1:0]   data;
      if ($urandom_range(0, 99) < 75) begin
         off = decoded_offset($urandom_range(0, NUM_DECODED - 1));
         if ($urandom_range(0, 9) == 0)
            kind = vnmr_pkg::KIND_EVENT;
         else
            kind = $urandom_range(0, 1) ? vnmr_pkg::KIND_WRITE : vnmr_pkg::KIND_READ;
         // small values for selects, values near the queue size, notify value 1
         case ($urandom_range(0, 7))
            0:       data = '0;
            1:       data = '1;
            2, 3:    data = $urandom_range(0, 2);
            4:       data = $urandom_range(QSIZE - 1, QSIZE + 1);
            default: data = $urandom;
         endcase
      end else begin
         off  = vnmr_pkg::OFFSET_W'($urandom_range(0, 4095));
         kind = vnmr_pkg::KIND_W'($urandom_range(0, 2));
         data = $urandom;
      end
      send_access(kind, off, data,
                  vnmr_pkg::BYTES_W'($urandom_range(1, vnmr_pkg::MAX_READ_BYTES)));
   endtask

   task automatic test_identity_reads();
      send_access(vnmr_pkg::KIND_READ, vnmr_pkg::OFF_MAGIC, $urandom, 4);
      send_access(vnmr_pkg::KIND_READ, vnmr_pkg::OFF_VERSION, $urandom, 4);
      send_access(vnmr_pkg::KIND_READ, vnmr_pkg::OFF_DEVICE_ID, $urandom, 4);
      send_access(vnmr_pkg::KIND_READ, vnmr_pkg::OFF_VENDOR_ID, $urandom, 1);
      send_access(vnmr_pkg::KIND_READ, vnmr_pkg::OFF_QUEUE_MAX, $urandom, 4);
      send_access(vnmr_pkg::KIND_READ, 12'hFFF, $urandom, 4);
   endtask

   task automatic test_feature_negotiation();
      send_access(vnmr_pkg::KIND_WRITE, vnmr_pkg::OFF_DEV_FEAT_S, 32'd1, 4);
      send_access(vnmr_pkg::KIND_READ, vnmr_pkg::OFF_DEV_FEAT, '0, 4);
      // select beyond the high half reads zero
      send_access(vnmr_pkg::KIND_WRITE, vnmr_pkg::OFF_DEV_FEAT_S, '1, 4);
      send_access(vnmr_pkg::KIND_READ, vnmr_pkg::OFF_DEV_FEAT, '0, 4);
      send_access(vnmr_pkg::KIND_WRITE, vnmr_pkg::OFF_DRV_FEAT, '1, 4);
      // driver half write with select beyond one is dropped
      send_access(vnmr_pkg::KIND_WRITE, vnmr_pkg::OFF_DRV_FEAT_S, 32'd2, 4);
      send_access(vnmr_pkg::KIND_WRITE, vnmr_pkg::OFF_DRV_FEAT, '0, 4);
   endtask

   task automatic test_queue_setup();
      send_access(vnmr_pkg::KIND_WRITE, vnmr_pkg::OFF_QUEUE_SEL, 32'd1, 4);
      send_access(vnmr_pkg::KIND_WRITE, vnmr_pkg::OFF_QUEUE_NUM, '1, 4);
      send_access(vnmr_pkg::KIND_WRITE, vnmr_pkg::OFF_QUEUE_READY, 32'd1, 4);
      send_access(vnmr_pkg::KIND_READ, vnmr_pkg::OFF_QUEUE_READY, '0, 4);
      // out of range queue: ready write dropped (a read would return zero)
      send_access(vnmr_pkg::KIND_WRITE, vnmr_pkg::OFF_QUEUE_SEL, NQ, 4);
      send_access(vnmr_pkg::KIND_WRITE, vnmr_pkg::OFF_QUEUE_READY, 32'd1, 4);
   endtask

   task automatic test_notify_and_irq();
      send_access(vnmr_pkg::KIND_WRITE, vnmr_pkg::OFF_NOTIFY, 32'd1, 4);
      send_access(vnmr_pkg::KIND_WRITE, vnmr_pkg::OFF_NOTIFY, 32'd0, 4);
      send_access(vnmr_pkg::KIND_EVENT, vnmr_pkg::OFF_MAGIC, '0, 4);
      send_access(vnmr_pkg::KIND_READ, vnmr_pkg::OFF_IRQ_STATUS, '0, 4);
      send_access(vnmr_pkg::KIND_WRITE, vnmr_pkg::OFF_IRQ_ACK, 32'd1, 4);
      send_access(vnmr_pkg::KIND_WRITE, vnmr_pkg::OFF_STATUS, '1, 4);
      send_access(vnmr_pkg::KIND_READ, vnmr_pkg::OFF_STATUS, '0, 4);
      // status write of zero clears queues and interrupt status
      send_access(vnmr_pkg::KIND_WRITE, vnmr_pkg::OFF_STATUS, '0, 4);
   endtask

   task automatic test_station_address();
      drain();
      program_station_address(64'hFFFF_0605_0403_0201);
      send_access(vnmr_pkg::KIND_READ, vnmr_pkg::OFF_CONFIG, '0, 4);
      send_access(vnmr_pkg::KIND_READ, vnmr_pkg::OFF_CONFIG + 12'd2, '0, 4);
      // last byte only, the rest past the address reads zero
      send_access(vnmr_pkg::KIND_READ, vnmr_pkg::OFF_CONFIG + 12'd5, '0, 4);
      send_access(vnmr_pkg::KIND_READ, vnmr_pkg::OFF_CONFIG + 12'd1, '0, 1);
   endtask

   task automatic test_register_traffic(input int count,
                                        input logic [vnmr_pkg::CSR_DATA_W-1:0] mac,
                                        input bit bursty);
      int i;
      drain();
      program_station_address(mac);
      idle_on = bursty;
      for (i = 0; i < count; i++)
         send_random_access();
      idle_on = 1'b1;
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      int i;
      rsp_hold_cycles = 300;
      for (i = 0; i < 40; i++)
         send_random_access();
   endtask

   initial begin
      reset            <= 1'b1;
      req.valid        <= 1'b0;
      req.kind         <= vnmr_pkg::KIND_READ;
      req.reg_offset   <= '0;
      req.write_data   <= '0;
      req.access_bytes <= vnmr_pkg::BYTES_W'(1);
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      idle_on         = 1'b1;
      rsp_hold_cycles = 0;
      mismatch_count  = 0;
      reset_register_mirror();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      program_station_address({$urandom, $urandom});

      test_identity_reads();
      test_feature_negotiation();
      test_queue_setup();
      test_notify_and_irq();
      test_station_address();
      test_register_traffic(380, '0, 1'b1);
      test_register_traffic(380, '1, 1'b0);
      test_register_traffic(380, {$urandom, $urandom}, 1'b1);
      test_backpressure();
      test_register_traffic(380, {$urandom, $urandom}, 1'b1);

      drain();
      if (mismatch_count == 0 && mmio_results_due.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/vnmr_pkg.sv
sv/vnmr_if.sv
sv/virtio_net_mmio_registers_unit.sv
tb/tb_top.sv
